@@ src/mts_pkg.sv @@
// Shared types and constants for the min-tracking stack.
package mts_pkg;

  // Width of one stored value.
  localparam int unsigned DataW = 32;

  // Default number of entries in each stack.
  localparam int unsigned DepthDefault = 64;

  // Width of the reported depth field.
  localparam int unsigned DepthFieldW = 7;

  // Width and codes of the status field.
  localparam int unsigned StatusW = 2;
  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_UNDERFLOW = 2'd2;

  // Operation codes.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Shift command shared by every cell of one chain.
  typedef struct packed {
    logic push;  // load from the neighbor above (toward the top)
    logic pop;   // load from the neighbor below
  } mts_shift_t;

endpackage

@@ src/mts_cell.sv @@
// One storage cell of a shift-register stack chain.
module mts_cell (
  input  logic                           clk_i,
  input  mts_pkg::mts_shift_t            shift_i,
  input  logic [mts_pkg::DataW-1:0]      above_i,
  input  logic [mts_pkg::DataW-1:0]      below_i,
  output logic [mts_pkg::DataW-1:0]      data_o
);

  logic [mts_pkg::DataW-1:0] data_q;
  logic [mts_pkg::DataW-1:0] data_d;

  always_comb begin
    priority if (shift_i.push) begin
      data_d = above_i;
    end else if (shift_i.pop) begin
      data_d = below_i;
    end else begin
      data_d = data_q;
    end
  end

  // Payload only: no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ src/min_tracking_stack_top.sv @@
// Top level of the min-tracking stack: two shift-register chains plus control.
//
// Min-tracking stack. Each request is a push of a signed 32-bit value
// (func_i = 0) or a pop (func_i = 1) and yields exactly one result carrying
// the new top, the smallest value held, the depth, an empty flag and a
// status (ok, overflow push ignored, underflow pop ignored). Top and minimum
// read 0 when the stack is empty. Storage is two rows of DEPTH identical
// cells, one for values and one for the run of minimums; entry 0 of each row
// is the top, and a push or pop shifts the whole row by one place, so the
// tops are always at a fixed cell and need no memory read. The result of an
// accepted request is loaded into the output register on the same edge that
// takes the request; requests can follow back to back, one per cycle, as
// long as the result side does not stall. While the output register
// holds a result that is stalled, in_stall_o is raised and no new
// request is taken. No clearing pass is needed after reset: the counts alone
// decide which cells are meaningful.
module min_tracking_stack_top #(
  parameter int unsigned DEPTH = mts_pkg::DepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic signed [mts_pkg::DataW-1:0]    value_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mts_pkg::DataW-1:0]    top_value_o,
  output logic signed [mts_pkg::DataW-1:0]    min_value_o,
  output logic [mts_pkg::DepthFieldW-1:0]     depth_now_o,
  output logic                                is_empty_o,
  output logic [mts_pkg::StatusW-1:0]         status_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned DW   = mts_pkg::DataW;

  // Occupancy of each chain.
  logic [CntW-1:0] val_cnt_q, val_cnt_d;
  logic [CntW-1:0] min_cnt_q, min_cnt_d;

  // Cell contents, index 0 is the top.
  logic [DW-1:0] val_cell [DEPTH];
  logic [DW-1:0] min_cell [DEPTH];

  mts_pkg::mts_shift_t val_shift;
  mts_pkg::mts_shift_t min_shift;

  // Output register.
  logic                              out_valid_q;
  logic [DW-1:0]                     top_q, min_q;
  logic [CntW-1:0]                   cnt_out_q;
  logic [mts_pkg::StatusW-1:0]       status_q;

  logic accept;
  logic is_push, is_pop;
  logic val_full, val_empty, min_empty;
  logic min_take, min_drop;
  logic [DW-1:0] top_next, min_next;
  logic [mts_pkg::StatusW-1:0] status_next;
  logic [31:0] cnt_wide;

  // Hold the request side while a finished result is stalled.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_push = accept && (func_i == mts_pkg::FUNC_PUSH);
  assign is_pop  = accept && (func_i == mts_pkg::FUNC_POP);

  assign val_full  = (val_cnt_q == CntW'(DEPTH));
  assign val_empty = (val_cnt_q == '0);
  assign min_empty = (min_cnt_q == '0);

  // Push onto the minimum run when it is empty or the value does not exceed
  // its top; drop the minimum top when the popped value equals it.
  assign min_take = is_push && !val_full && (min_cnt_q != CntW'(DEPTH)) &&
                    (min_empty || (value_i <= $signed(min_cell[0])));
  assign min_drop = is_pop && !val_empty && !min_empty && (val_cell[0] == min_cell[0]);

  assign val_shift.push = is_push && !val_full;
  assign val_shift.pop  = is_pop && !val_empty;
  assign min_shift.push = min_take;
  assign min_shift.pop  = min_drop;

  always_comb begin
    val_cnt_d = val_cnt_q;
    min_cnt_d = min_cnt_q;
    if (val_shift.push) val_cnt_d = val_cnt_q + CntW'(1);
    if (val_shift.pop)  val_cnt_d = val_cnt_q - CntW'(1);
    if (min_take)       min_cnt_d = min_cnt_q + CntW'(1);
    if (min_drop)       min_cnt_d = min_cnt_q - CntW'(1);
  end

  // Advance both chains.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cells
    logic [DW-1:0] val_above, val_below, min_above, min_below;

    if (i == 0) begin : g_head
      assign val_above = value_i;
      assign min_above = value_i;
    end else begin : g_mid_above
      assign val_above = val_cell[i-1];
      assign min_above = min_cell[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign val_below = val_cell[i];
      assign min_below = min_cell[i];
    end else begin : g_mid_below
      assign val_below = val_cell[i+1];
      assign min_below = min_cell[i+1];
    end

    mts_cell u_val_cell (
      .clk_i   (clk_i),
      .shift_i (val_shift),
      .above_i (val_above),
      .below_i (val_below),
      .data_o  (val_cell[i])
    );

    mts_cell u_min_cell (
      .clk_i   (clk_i),
      .shift_i (min_shift),
      .above_i (min_above),
      .below_i (min_below),
      .data_o  (min_cell[i])
    );
  end

  // Tops after this request, read from the cells around entry 0.
  always_comb begin
    priority if (val_shift.push) begin
      top_next = value_i;
    end else if (val_shift.pop) begin
      top_next = val_cell[1];
    end else begin
      top_next = val_cell[0];
    end

    priority if (min_take) begin
      min_next = value_i;
    end else if (min_drop) begin
      min_next = min_cell[1];
    end else begin
      min_next = min_cell[0];
    end

    if (val_cnt_d == '0) top_next = '0;
    if (val_cnt_d == '0 || min_cnt_d == '0) min_next = '0;

    priority if (is_push && val_full) begin
      status_next = mts_pkg::STATUS_OVERFLOW;
    end else if (is_pop && val_empty) begin
      status_next = mts_pkg::STATUS_UNDERFLOW;
    end else begin
      status_next = mts_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_cnt_q   <= '0;
      min_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      val_cnt_q <= val_cnt_d;
      min_cnt_q <= min_cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded on accept only.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_q     <= top_next;
      min_q     <= min_next;
      cnt_out_q <= val_cnt_d;
      status_q  <= status_next;
    end
  end

  assign cnt_wide    = 32'(cnt_out_q);
  assign out_valid_o = out_valid_q;
  assign top_value_o = $signed(top_q);
  assign min_value_o = $signed(min_q);
  assign depth_now_o = cnt_wide[mts_pkg::DepthFieldW-1:0];
  assign is_empty_o  = (cnt_out_q == '0);
  assign status_o    = status_q;

endmodule
